@@ sv/c8cs_codec_pkg.sv @@
// Package for the CRC-8 command/state frame codec.
// Holds frame constants, field codes and the CRC-8 byte update function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c8cs_codec_pkg;

   localparam int CMD_LEN = 9;
   localparam int BEAT_W = 4;
   localparam int COUNT_W = 4;
   localparam int CSR_INDEX_W = 1;

   localparam logic [BEAT_W-1:0] CMD_LAST = BEAT_W'(CMD_LEN - 1);

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;
   localparam logic [7:0] GRIP_MAX = 8'd180;

   localparam logic [7:0] COMMAND_HEADER_RESET = 8'd165;
   localparam logic [7:0] STATE_HEADER_RESET = 8'd90;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_HEADER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATE_HEADER = 1'b1;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_RECEIVE = 1'b1;

   localparam logic KIND_CMD_BYTE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef logic [7:0] byte_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic byte_type crc_byte(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/crc8_command_state_frame_codec_core.sv @@
// Top level of the CRC-8 command/state frame codec.
// Depends on c8cs_codec_pkg for constants and the CRC-8 byte update.
//
//   channel  prefix  direction  word
//   input    req_    in         one command item or one received byte
//   result   rsp_    out        one command frame byte or one frame report
//   config   csr_    in         one header register write
//
// A command item produces nine result words, one per cycle while rsp_ready is high;
// the serializer updates the frame CRC one byte per emitted word.
// A received byte updates the receive state; the final byte of a state frame yields a report.
// An input register holds one item, so a new item is taken while results are still draining.
// Reset is synchronous and active high; it clears control state and reloads the header defaults.
`timescale 1ns / 1ps
`default_nettype none

module crc8_command_state_frame_codec_core #(
   parameter int STATE_LEN = 8
) (
   input  wire                                      clock,
   input  wire                                      reset,

   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  wire                                      req_mode,
   input  wire  [7:0]                               req_tx_seq,
   input  wire  signed [15:0]                       req_tx_angle_one,
   input  wire  signed [15:0]                       req_tx_angle_two,
   input  wire  [7:0]                               req_tx_grip,
   input  wire                                      req_tx_enable,
   input  wire                                      req_tx_brake,
   input  wire                                      req_tx_clear_fault,
   input  wire  [7:0]                               req_rx_byte,
   input  wire                                      req_rx_start,

   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output logic                                     rsp_result_kind,
   output logic [7:0]                               rsp_frame_byte,
   output logic                                     rsp_last_byte,
   output logic                                     rsp_frame_ok,
   output logic [7:0]                               rsp_rx_seq_out,
   output logic signed [15:0]                       rsp_rx_angle_one,
   output logic signed [15:0]                       rsp_rx_angle_two,
   output logic [7:0]                               rsp_rx_status,

   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire  [c8cs_codec_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [7:0]                               csr_data
);

   import c8cs_codec_pkg::*;

   localparam logic [COUNT_W-1:0] STATE_LAST = COUNT_W'(STATE_LEN - 1);

   // Configuration registers.
   logic [7:0] command_header_ff, command_header_in;
   logic [7:0] state_header_ff, state_header_in;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic        in_mode_ff;
   logic [7:0]  in_seq_ff;
   logic [15:0] in_angle_one_ff;
   logic [15:0] in_angle_two_ff;
   logic [7:0]  in_grip_ff;
   logic [2:0]  in_flags_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;

   // Receive state.
   logic [7:0]         rx_crc_ff, rx_crc_in;
   logic [COUNT_W-1:0] rx_count_ff, rx_count_in;
   logic               rx_header_match_ff, rx_header_match_in;
   logic [7:0]         rx_seq_hold_ff, rx_seq_hold_in;
   logic [15:0]        rx_angle_one_hold_ff, rx_angle_one_hold_in;
   logic [15:0]        rx_angle_two_hold_ff, rx_angle_two_hold_in;
   logic [7:0]         rx_status_hold_ff, rx_status_hold_in;

   // Result stage.
   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [7:0]        tx_crc_ff, tx_crc_in;
   logic [7:0]        tx_buf_ff [0:CMD_LEN-2];
   logic [7:0]        tx_buf_in [0:CMD_LEN-2];
   logic              rep_ok_ff, rep_ok_in;
   logic [7:0]        rep_seq_ff, rep_seq_in;
   logic [15:0]       rep_angle_one_ff, rep_angle_one_in;
   logic [15:0]       rep_angle_two_ff, rep_angle_two_in;
   logic [7:0]        rep_status_ff, rep_status_in;

   logic               rsp_fire;
   logic               out_done;
   logic               out_free;
   logic               advance;
   logic               produces;
   logic [COUNT_W-1:0] rx_idx;
   logic               rx_final;
   logic [7:0]         rx_crc_base;
   logic               rx_ok;
   logic [7:0]         grip_sat;

   assign csr_ready = 1'b1;

   always_comb begin
      command_header_in = command_header_ff;
      state_header_in = state_header_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COMMAND_HEADER: command_header_in = csr_data;
            CSR_STATE_HEADER:   state_header_in = csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_fire = out_valid_ff && rsp_ready;
   assign out_done = rsp_fire && ((out_kind_ff == KIND_REPORT) || (beat_ff == CMD_LAST));
   assign out_free = !out_valid_ff || out_done;

   assign rx_idx = in_start_ff ? '0 : rx_count_ff;
   assign rx_final = (rx_idx == STATE_LAST);
   assign produces = (in_mode_ff == MODE_ENCODE) || rx_final;
   assign advance = in_valid_ff && (out_free || !produces);

   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   assign rx_crc_base = (rx_idx == '0) ? CRC_INIT : rx_crc_ff;
   assign rx_ok = rx_header_match_ff && (rx_crc_ff == in_byte_ff);
   assign grip_sat = (in_grip_ff > GRIP_MAX) ? GRIP_MAX : in_grip_ff;

   always_comb begin
      rx_crc_in = rx_crc_ff;
      rx_count_in = rx_count_ff;
      rx_header_match_in = rx_header_match_ff;
      rx_seq_hold_in = rx_seq_hold_ff;
      rx_angle_one_hold_in = rx_angle_one_hold_ff;
      rx_angle_two_hold_in = rx_angle_two_hold_ff;
      rx_status_hold_in = rx_status_hold_ff;
      if (advance && (in_mode_ff == MODE_RECEIVE)) begin
         if (rx_final) begin
            rx_count_in = '0;
         end else begin
            rx_crc_in = crc_byte(rx_crc_base, in_byte_ff);
            rx_count_in = rx_idx + COUNT_W'(1);
            if (rx_idx == COUNT_W'(0)) begin
               rx_header_match_in = (in_byte_ff == state_header_ff);
            end
            if (rx_idx == COUNT_W'(1)) begin
               rx_seq_hold_in = in_byte_ff;
            end
            if (rx_idx == COUNT_W'(2)) begin
               rx_angle_one_hold_in[15:8] = in_byte_ff;
            end
            if (rx_idx == COUNT_W'(3)) begin
               rx_angle_one_hold_in[7:0] = in_byte_ff;
            end
            if (rx_idx == COUNT_W'(4)) begin
               rx_angle_two_hold_in[15:8] = in_byte_ff;
            end
            if (rx_idx == COUNT_W'(5)) begin
               rx_angle_two_hold_in[7:0] = in_byte_ff;
            end
            if (rx_idx == COUNT_W'(6)) begin
               rx_status_hold_in = in_byte_ff;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in = out_kind_ff;
      beat_in = beat_ff;
      tx_crc_in = tx_crc_ff;
      for (int i = 0; i < CMD_LEN - 1; i++) begin
         tx_buf_in[i] = tx_buf_ff[i];
      end
      rep_ok_in = rep_ok_ff;
      rep_seq_in = rep_seq_ff;
      rep_angle_one_in = rep_angle_one_ff;
      rep_angle_two_in = rep_angle_two_ff;
      rep_status_in = rep_status_ff;

      if (advance && produces) begin
         out_valid_in = 1'b1;
         beat_in = '0;
         tx_crc_in = CRC_INIT;
         tx_buf_in[0] = command_header_ff;
         tx_buf_in[1] = in_seq_ff;
         tx_buf_in[2] = in_angle_one_ff[15:8];
         tx_buf_in[3] = in_angle_one_ff[7:0];
         tx_buf_in[4] = in_angle_two_ff[15:8];
         tx_buf_in[5] = in_angle_two_ff[7:0];
         tx_buf_in[6] = grip_sat;
         tx_buf_in[7] = {5'b0, in_flags_ff};
         if (in_mode_ff == MODE_ENCODE) begin
            out_kind_in = KIND_CMD_BYTE;
            rep_ok_in = 1'b0;
            rep_seq_in = '0;
            rep_angle_one_in = '0;
            rep_angle_two_in = '0;
            rep_status_in = '0;
         end else begin
            out_kind_in = KIND_REPORT;
            rep_ok_in = rx_ok;
            rep_seq_in = rx_ok ? rx_seq_hold_ff : 8'h00;
            rep_angle_one_in = rx_ok ? rx_angle_one_hold_ff : 16'h0000;
            rep_angle_two_in = rx_ok ? rx_angle_two_hold_ff : 16'h0000;
            rep_status_in = rx_ok ? rx_status_hold_ff : 8'h00;
         end
      end else if (out_done) begin
         out_valid_in = 1'b0;
      end else if (rsp_fire) begin
         beat_in = beat_ff + BEAT_W'(1);
         tx_crc_in = crc_byte(tx_crc_ff, tx_buf_ff[0]);
         for (int i = 0; i < CMD_LEN - 2; i++) begin
            tx_buf_in[i] = tx_buf_ff[i+1];
         end
         tx_buf_in[CMD_LEN-2] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_header_ff <= COMMAND_HEADER_RESET;
         state_header_ff <= STATE_HEADER_RESET;
         in_valid_ff <= 1'b0;
         rx_crc_ff <= '0;
         rx_count_ff <= '0;
         rx_header_match_ff <= 1'b0;
         rx_seq_hold_ff <= '0;
         rx_angle_one_hold_ff <= '0;
         rx_angle_two_hold_ff <= '0;
         rx_status_hold_ff <= '0;
         out_valid_ff <= 1'b0;
         out_kind_ff <= KIND_CMD_BYTE;
         beat_ff <= '0;
      end else begin
         command_header_ff <= command_header_in;
         state_header_ff <= state_header_in;
         in_valid_ff <= in_valid_in;
         rx_crc_ff <= rx_crc_in;
         rx_count_ff <= rx_count_in;
         rx_header_match_ff <= rx_header_match_in;
         rx_seq_hold_ff <= rx_seq_hold_in;
         rx_angle_one_hold_ff <= rx_angle_one_hold_in;
         rx_angle_two_hold_ff <= rx_angle_two_hold_in;
         rx_status_hold_ff <= rx_status_hold_in;
         out_valid_ff <= out_valid_in;
         out_kind_ff <= out_kind_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= req_mode;
         in_seq_ff <= req_tx_seq;
         in_angle_one_ff <= req_tx_angle_one;
         in_angle_two_ff <= req_tx_angle_two;
         in_grip_ff <= req_tx_grip;
         in_flags_ff <= {req_tx_clear_fault, req_tx_brake, req_tx_enable};
         in_byte_ff <= req_rx_byte;
         in_start_ff <= req_rx_start;
      end
      tx_crc_ff <= tx_crc_in;
      for (int i = 0; i < CMD_LEN - 1; i++) begin
         tx_buf_ff[i] <= tx_buf_in[i];
      end
      rep_ok_ff <= rep_ok_in;
      rep_seq_ff <= rep_seq_in;
      rep_angle_one_ff <= rep_angle_one_in;
      rep_angle_two_ff <= rep_angle_two_in;
      rep_status_ff <= rep_status_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_frame_byte = (out_kind_ff == KIND_REPORT) ? 8'h00 :
                           ((beat_ff == CMD_LAST) ? tx_crc_ff : tx_buf_ff[0]);
   assign rsp_last_byte = (out_kind_ff == KIND_CMD_BYTE) && (beat_ff == CMD_LAST);
   assign rsp_frame_ok = rep_ok_ff;
   assign rsp_rx_seq_out = rep_seq_ff;
   assign rsp_rx_angle_one = rep_angle_one_ff;
   assign rsp_rx_angle_two = rep_angle_two_ff;
   assign rsp_rx_status = rep_status_ff;

`ifndef SYNTHESIS
   a_beat_range : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_kind_ff == KIND_CMD_BYTE) |-> beat_ff <= CMD_LAST)
      else $error("command beat counter ran past the CRC byte");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rx_count_ff < STATE_LAST + COUNT_W'(1))
      else $error("receive byte index left the frame");

   a_new_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_byte |=> !rsp_valid || (beat_ff == '0))
      else $error("result after a final command byte did not start fresh");

   a_report_load : assert property (@(posedge clock) disable iff (reset)
      advance && produces && (in_mode_ff == MODE_RECEIVE) |=>
      rsp_valid && (rsp_result_kind == KIND_REPORT))
      else $error("final state byte did not produce a report");

   a_report_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_REPORT) |->
      !rsp_last_byte && (rsp_frame_byte == 8'h00))
      else $error("report word marked as a command byte");
`endif

endmodule

`default_nettype wire

@@ dv/tb_crc8_command_state_frame_codec_core.sv @@
// Testbench for crc8_command_state_frame_codec_core: command frames and received state frames.
// It predicts every result word, checks each one as it leaves, and changes both header registers.
// Depends on c8cs_codec_pkg and the codec core RTL.
`timescale 1ns / 1ps

module tb_crc8_command_state_frame_codec_core;
   import c8cs_codec_pkg::*;

   localparam int STATE_BYTES = 8;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic              mode;
      logic [7:0]        seq;
      logic signed [15:0] a1;
      logic signed [15:0] a2;
      logic [7:0]        grip;
      logic              en;
      logic              brk;
      logic              clr;
      logic [7:0]        rxb;
      logic              rxs;
   } codec_item_type;

   typedef struct {
      logic              kind;
      logic [7:0]        fbyte;
      logic              last;
      logic              ok;
      logic [7:0]        seq;
      logic signed [15:0] a1;
      logic signed [15:0] a2;
      logic [7:0]        status;
   } codec_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = MODE_ENCODE;
   logic [7:0]        req_tx_seq = '0;
   logic signed [15:0] req_tx_angle_one = '0;
   logic signed [15:0] req_tx_angle_two = '0;
   logic [7:0]        req_tx_grip = '0;
   logic              req_tx_enable = 1'b0;
   logic              req_tx_brake = 1'b0;
   logic              req_tx_clear_fault = 1'b0;
   logic [7:0]        req_rx_byte = '0;
   logic              req_rx_start = 1'b0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_result_kind;
   logic [7:0]        rsp_frame_byte;
   logic              rsp_last_byte;
   logic              rsp_frame_ok;
   logic [7:0]        rsp_rx_seq_out;
   logic signed [15:0] rsp_rx_angle_one;
   logic signed [15:0] rsp_rx_angle_two;
   logic [7:0]        rsp_rx_status;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_COMMAND_HEADER;
   logic [7:0]             csr_data = '0;

   codec_word_type due_words[$];

   logic [7:0]  cmd_hdr;
   logic [7:0]  state_hdr;
   int          rx_pos;
   logic [7:0]  rx_sum;
   logic        rx_hdr_ok;
   logic [7:0]  rx_seq_l;
   logic [15:0] rx_a1_l;
   logic [15:0] rx_a2_l;
   logic [7:0]  rx_stat_l;

   logic [7:0] gen_state_hdr = STATE_HEADER_RESET;
   int gen_rx_pos = 0;
   bit no_idle = 0;
   int hold_request = 0;

   int mismatches = 0;
   int sent_items = 0;
   int cmd_items = 0;
   int rx_bytes = 0;
   int words_checked = 0;
   int reports_checked = 0;
   int header_settings = 1;
   int cycle_count = 0;

   crc8_command_state_frame_codec_core #(
      .STATE_LEN(STATE_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_tx_seq(req_tx_seq),
      .req_tx_angle_one(req_tx_angle_one),
      .req_tx_angle_two(req_tx_angle_two),
      .req_tx_grip(req_tx_grip),
      .req_tx_enable(req_tx_enable),
      .req_tx_brake(req_tx_brake),
      .req_tx_clear_fault(req_tx_clear_fault),
      .req_rx_byte(req_rx_byte),
      .req_rx_start(req_rx_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte),
      .rsp_frame_ok(rsp_frame_ok),
      .rsp_rx_seq_out(rsp_rx_seq_out),
      .rsp_rx_angle_one(rsp_rx_angle_one),
      .rsp_rx_angle_two(rsp_rx_angle_two),
      .rsp_rx_status(rsp_rx_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding.",
                  cycle_count, due_words.size());
         $display("crc8_command_state_frame_codec_core verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] r;
      r = acc ^ d;
      repeat (8) begin
         r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   task automatic append_due(input codec_word_type w);
      due_words = {due_words, w};
   endtask

   task automatic predict_command_frame(input codec_item_type it);
      logic [7:0] fr [CMD_LEN];
      logic [7:0] sum;
      codec_word_type w;
      int k;
      fr[0] = cmd_hdr;
      fr[1] = it.seq;
      fr[2] = it.a1[15:8];
      fr[3] = it.a1[7:0];
      fr[4] = it.a2[15:8];
      fr[5] = it.a2[7:0];
      fr[6] = (it.grip > GRIP_MAX) ? GRIP_MAX : it.grip;
      fr[7] = {5'b0, it.clr, it.brk, it.en};
      sum = CRC_INIT;
      for (k = 0; k < CMD_LEN - 1; k++) begin
         sum = crc8_next(sum, fr[k]);
      end
      fr[CMD_LEN-1] = sum;
      for (k = 0; k < CMD_LEN; k++) begin
         w = '{default: '0};
         w.kind = KIND_CMD_BYTE;
         w.fbyte = fr[k];
         w.last = (k == CMD_LEN - 1);
         append_due(w);
      end
   endtask

   task automatic predict_state_byte(input codec_item_type it);
      codec_word_type w;
      if (it.rxs) begin
         rx_pos = 0;
      end
      if (rx_pos == 0) begin
         rx_sum = CRC_INIT;
         rx_hdr_ok = (it.rxb == state_hdr);
      end
      if (rx_pos < STATE_BYTES - 1) begin
         rx_sum = crc8_next(rx_sum, it.rxb);
         case (rx_pos)
            1: rx_seq_l = it.rxb;
            2: rx_a1_l[15:8] = it.rxb;
            3: rx_a1_l[7:0] = it.rxb;
            4: rx_a2_l[15:8] = it.rxb;
            5: rx_a2_l[7:0] = it.rxb;
            6: rx_stat_l = it.rxb;
            default: ;
         endcase
         rx_pos++;
      end else begin
         w = '{default: '0};
         w.kind = KIND_REPORT;
         if (rx_hdr_ok && rx_sum == it.rxb) begin
            w.ok = 1'b1;
            w.seq = rx_seq_l;
            w.a1 = rx_a1_l;
            w.a2 = rx_a2_l;
            w.status = rx_stat_l;
         end
         append_due(w);
         rx_pos = 0;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_result_word();
      codec_word_type w;
      if (due_words.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected word, kind %0d byte %0h ok %0d, expected none",
                  $time, rsp_result_kind, rsp_frame_byte, rsp_frame_ok);
      end else begin
         w = due_words.pop_front();
         words_checked++;
         if (w.kind == KIND_REPORT) begin
            reports_checked++;
         end
         check_field("result_kind", w.kind, rsp_result_kind);
         check_field("frame_byte", w.fbyte, rsp_frame_byte);
         check_field("last_byte", w.last, rsp_last_byte);
         check_field("frame_ok", w.ok, rsp_frame_ok);
         check_field("rx_seq_out", w.seq, rsp_rx_seq_out);
         check_field("rx_angle_one", w.a1, rsp_rx_angle_one);
         check_field("rx_angle_two", w.a2, rsp_rx_angle_two);
         check_field("rx_status", w.status, rsp_rx_status);
      end
   endtask

   always @(posedge clock) begin : monitor
      codec_item_type it;
      if (reset) begin
         cmd_hdr = COMMAND_HEADER_RESET;
         state_hdr = STATE_HEADER_RESET;
         rx_pos = 0;
         rx_sum = '0;
         rx_hdr_ok = 1'b0;
         rx_seq_l = '0;
         rx_a1_l = '0;
         rx_a2_l = '0;
         rx_stat_l = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COMMAND_HEADER) begin
               cmd_hdr = csr_data;
            end else if (csr_index == CSR_STATE_HEADER) begin
               state_hdr = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            it.mode = req_mode;
            it.seq = req_tx_seq;
            it.a1 = req_tx_angle_one;
            it.a2 = req_tx_angle_two;
            it.grip = req_tx_grip;
            it.en = req_tx_enable;
            it.brk = req_tx_brake;
            it.clr = req_tx_clear_fault;
            it.rxb = req_rx_byte;
            it.rxs = req_rx_start;
            if (it.mode == MODE_ENCODE) begin
               predict_command_frame(it);
            end else begin
               predict_state_byte(it);
            end
         end
         if (rsp_valid && rsp_ready) begin
            check_result_word();
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // The receiver alternates runs of ready with stalls; a requested hold overrides both.
   initial begin : receiver
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            stall_left = hold_request;
            hold_request = 0;
            run_left = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (no_idle || run_left > 0) begin
            rsp_ready <= 1'b1;
            if (run_left > 0) begin
               run_left--;
            end
         end else begin
            rsp_ready <= 1'b1;
            run_left = $urandom_range(1, 16);
            stall_left = pick_gap();
         end
      end
   end

   function automatic codec_item_type random_item();
      codec_item_type it;
      it.mode = MODE_ENCODE;
      it.seq = 8'($urandom);
      it.a1 = 16'($urandom);
      it.a2 = 16'($urandom);
      it.grip = 8'($urandom);
      it.en = 1'($urandom);
      it.brk = 1'($urandom);
      it.clr = 1'($urandom);
      it.rxb = 8'($urandom);
      it.rxs = 1'($urandom);
      return it;
   endfunction

   function automatic logic signed [15:0] pick_angle();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(input codec_item_type it, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_tx_seq <= it.seq;
      req_tx_angle_one <= it.a1;
      req_tx_angle_two <= it.a2;
      req_tx_grip <= it.grip;
      req_tx_enable <= it.en;
      req_tx_brake <= it.brk;
      req_tx_clear_fault <= it.clr;
      req_rx_byte <= it.rxb;
      req_rx_start <= it.rxs;
      do @(posedge clock); while (req_ready !== 1'b1);
      sent_items++;
      if (it.mode == MODE_ENCODE) begin
         cmd_items++;
      end else begin
         rx_bytes++;
         gen_rx_pos = it.rxs ? 1 : (gen_rx_pos + 1) % STATE_BYTES;
      end
   endtask

   task automatic send_command(input logic [7:0] seq, input logic signed [15:0] a1,
                               input logic signed [15:0] a2, input logic [7:0] grip,
                               input logic en, input logic brk, input logic clr);
      codec_item_type it;
      it = random_item();
      it.mode = MODE_ENCODE;
      it.seq = seq;
      it.a1 = a1;
      it.a2 = a2;
      it.grip = grip;
      it.en = en;
      it.brk = brk;
      it.clr = clr;
      send_item(it, pick_gap());
   endtask

   task automatic send_random_command();
      logic [7:0] grip;
      grip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(175, 185)) : 8'($urandom);
      send_command(8'($urandom), pick_angle(), pick_angle(), grip,
                   1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic send_rx_byte(input logic [7:0] b, input logic start);
      codec_item_type it;
      it = random_item();
      it.mode = MODE_RECEIVE;
      it.rxb = b;
      it.rxs = start;
      send_item(it, pick_gap());
   endtask

   // A frame is opened with a start flag when want_start is set or the receiver is not already at byte zero.
   task automatic send_state_frame(input bit hdr_good, input bit crc_good, input bit want_start,
                                   input bit mix_cmd, input logic [7:0] seq,
                                   input logic [15:0] a1, input logic [15:0] a2,
                                   input logic [7:0] status);
      logic [7:0] fb [STATE_BYTES];
      logic [7:0] sum;
      int i;
      fb[0] = hdr_good ? gen_state_hdr : gen_state_hdr ^ 8'($urandom_range(1, 255));
      fb[1] = seq;
      fb[2] = a1[15:8];
      fb[3] = a1[7:0];
      fb[4] = a2[15:8];
      fb[5] = a2[7:0];
      fb[6] = status;
      sum = CRC_INIT;
      for (i = 0; i < STATE_BYTES - 1; i++) begin
         sum = crc8_next(sum, fb[i]);
      end
      fb[STATE_BYTES-1] = crc_good ? sum : sum ^ 8'($urandom_range(1, 255));
      for (i = 0; i < STATE_BYTES; i++) begin
         if (mix_cmd && i == 3) begin
            send_random_command();
         end
         send_rx_byte(fb[i], i == 0 && (want_start || gen_rx_pos != 0));
      end
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (index == CSR_STATE_HEADER) begin
         gen_state_hdr = data;
      end
      @(posedge clock);
   endtask

   task automatic test_command_extremes();
      send_command(8'h00, 16'sh8000, 16'sh7FFF, 8'h00, 1'b0, 1'b0, 1'b0);
      send_command(8'hFF, 16'sh7FFF, 16'sh8000, 8'hFF, 1'b1, 1'b1, 1'b1);
      send_command(8'h5A, 16'sh0000, -16'sd1, 8'd181, 1'b1, 1'b0, 1'b1);
      send_command(8'hA5, 16'sh0001, -16'sd2, 8'd180, 1'b0, 1'b1, 1'b0);
   endtask

   task automatic test_state_frame_cases();
      send_state_frame(1, 1, 1, 0, 8'h00, 16'h8000, 16'h7FFF, 8'hFF);
      // The next frame follows without a start flag and carries a corrupted CRC.
      send_state_frame(1, 0, 0, 0, 8'hFF, 16'h7FFF, 16'h8000, 8'h00);
      send_rx_byte(gen_state_hdr, 1'b1);
      send_rx_byte(8'h3C, 1'b0);
      // A start flag mid-frame drops the partial frame; this one has a wrong header.
      send_state_frame(0, 1, 1, 0, 8'h81, 16'h1234, 16'hEDCB, 8'h02);
   endtask

   task automatic test_random_traffic(input int n);
      int first;
      int r;
      int k;
      first = sent_items;
      while (sent_items - first < n) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            send_random_command();
         end else if (r < 80) begin
            send_state_frame($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 80,
                             $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0,
                             8'($urandom), pick_angle(), pick_angle(), 8'($urandom));
         end else if (r < 90) begin
            send_rx_byte(($urandom_range(0, 3) != 0) ? gen_state_hdr : 8'($urandom), 1'b1);
            repeat ($urandom_range(0, STATE_BYTES - 3)) send_rx_byte(8'($urandom), 1'b0);
         end else begin
            k = $urandom_range(1, 4);
            repeat (k) send_rx_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end
      end
   endtask

   task automatic test_header_phase(input logic [7:0] cmd_value, input logic [7:0] st_value,
                                    input int n, input bit steady);
      settle_idle();
      write_csr(CSR_COMMAND_HEADER, cmd_value);
      write_csr(CSR_STATE_HEADER, st_value);
      header_settings++;
      no_idle = steady;
      test_random_traffic(n);
      no_idle = 0;
   endtask

   task automatic test_backpressure();
      hold_request = 200;
      no_idle = 1;
      repeat (6) send_random_command();
      send_state_frame(1, 1, 1, 0, 8'($urandom), pick_angle(), pick_angle(), 8'($urandom));
      no_idle = 0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_command_extremes();
      test_state_frame_cases();
      test_header_phase(8'h00, 8'hFF, 95, 0);
      test_header_phase(8'hFF, 8'h00, 95, 1);
      test_header_phase(8'($urandom), 8'($urandom), 95, 0);
      test_header_phase(COMMAND_HEADER_RESET, STATE_HEADER_RESET, 95, 0);
      test_backpressure();
      settle_idle();
      $display("Sent %0d command items and %0d received bytes under %0d header settings.",
               cmd_items, rx_bytes, header_settings);
      $display("Checked %0d result words, %0d of them frame reports, with %0d mismatches.",
               words_checked, reports_checked, mismatches);
      if (mismatches == 0 && due_words.size() == 0) begin
         $display("crc8_command_state_frame_codec_core verification clean");
      end else begin
         $display("crc8_command_state_frame_codec_core verification failed");
      end
      $finish;
   end

endmodule
